@@ design/dmht_pkg.sv @@
// Package for the djb2 direct-mapped hash table: word types, commands and constants.
package dmht_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;
	localparam int DEFAULT_VALUE_WIDTH = 64;

	localparam int HASH_W    = 64;
	localparam int SIZE_W    = 17;
	localparam int SLOT_OUT_W = 16;
	localparam int DIV_CNT_W = 6;   // counts HASH_W quotient bits

	localparam logic [HASH_W-1:0] HASH_SEED        = 64'd5381;
	localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 17'd16;

	localparam logic [1:0] CMD_INSERT   = 2'd0;
	localparam logic [1:0] CMD_REMOVE   = 2'd1;
	localparam logic [1:0] CMD_RETRIEVE = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  key_byte;
		logic        key_last;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [15:0] slot;
		logic [63:0] value_out;
	} rsp_t;

	// acc * 33 + byte, zero bytes skipped
	function automatic logic [HASH_W-1:0] djb2_fold(input logic [HASH_W-1:0] acc,
			input logic [7:0] b);
		logic [HASH_W-1:0] r;
		r = acc;
		if (b != 8'd0) begin
			r = (acc << 5) + acc + {{(HASH_W-8){1'b0}}, b};
		end
		return r;
	endfunction

endpackage

@@ design/direct_mapped_hash_table.sv @@
// Top level of the djb2 direct-mapped hash table: hash fold, serial modulo and slot memory.
//
// Usage:
//   Request channel: a word on request is taken at a clock edge with start high and
//   busy low. Each word carries one key byte. Bytes before the last fold into the
//   djb2 hash in that same edge and leave busy low, so a key streams at one byte per
//   cycle. The word with key_last set ends the key and carries the command.
//   Last byte: the hash is reduced modulo the table size by a restoring divider that
//   retires one quotient bit per cycle, then the slot is read (ST_READ) and the
//   command is applied (ST_RESP). done rises with response as ST_RESP ends; busy
//   is high from the edge that takes the last byte and drops as done rises, so no
//   further word is taken until done has risen.
//   Response channel: done marks response for exactly one cycle. The receiver
//   cannot stall; there is nothing to hold.
//   Config: table_size is written whenever table_size_we is high; write it only
//   while the block is idle. Zero acts as 1, values above TABLE_DEPTH saturate.
//   Reset: arst_n clears control, sets table_size to 16 and the hash to 5381, then
//   a clearing pass writes every slot empty, one slot a cycle, with busy high.
//   Keys are not stored: colliding keys share a slot.
module direct_mapped_hash_table
	import dmht_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              request,
	output logic              done,
	output rsp_t              response,
	input  logic              table_size_we,
	input  logic [SIZE_W-1:0] table_size
);

	localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [SIZE_W-1:0] DEPTH_SZ  = SIZE_W'(TABLE_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]             state_q;
	logic [SIZE_W-1:0]      table_size_q;
	logic [HASH_W-1:0]      acc_q;
	logic [HASH_W-1:0]      dvd_q;       // dividend, shifted out MSB first
	logic [SLOT_OUT_W-1:0]  rem_q;       // running remainder, ends as the slot
	logic [SIZE_W-1:0]      divisor_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]      clr_q;
	logic [1:0]             cmd_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH:0]   rd_q;        // {valid, value} read from the slot
	logic                   done_q;
	rsp_t                   rsp_q;

	// slot memory: {valid, value}
	logic [VALUE_WIDTH:0]   mem_q [TABLE_DEPTH];

	logic                   accept;
	logic [HASH_W-1:0]      hash_next;
	logic [SIZE_W-1:0]      eff_size;
	logic [SIZE_W-1:0]      trial;
	logic                   trial_ge;
	logic [SLOT_W-1:0]      slot_idx;
	logic                   rd_valid;
	logic                   mem_we;
	logic [SLOT_W-1:0]      mem_waddr;
	logic [VALUE_WIDTH:0]   mem_wdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign hash_next = djb2_fold(acc_q, request.key_byte);
	assign slot_idx  = rem_q[SLOT_W-1:0];
	assign rd_valid  = rd_q[VALUE_WIDTH];

	always_comb begin
		eff_size = table_size_q;
		if (table_size_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (table_size_q > DEPTH_SZ) begin
			eff_size = DEPTH_SZ;
		end
	end

	// one restoring-division step
	assign trial    = {rem_q, dvd_q[HASH_W-1]};
	assign trial_ge = (trial >= divisor_q);

	// single write port: clearing pass, or the command's update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_idx;
		mem_wdata = '0;
		priority if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (state_q == ST_RESP && cmd_q == CMD_INSERT) begin
			mem_we    = 1'b1;
			mem_wdata = {1'b1, val_q};
		end else if (state_q == ST_RESP && cmd_q == CMD_REMOVE) begin
			mem_we    = 1'b1;
			mem_wdata = {1'b0, rd_q[VALUE_WIDTH-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= mem_q[slot_idx];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && request.key_last) begin
			dvd_q     <= hash_next;
			divisor_q <= eff_size;
			cmd_q     <= request.command;
			val_q     <= request.value[VALUE_WIDTH-1:0];
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
		end
		if (state_q == ST_RESP) begin
			rsp_q.found     <= rd_valid;
			rsp_q.slot      <= rem_q;
			rsp_q.value_out <= (cmd_q == CMD_RETRIEVE && rd_valid) ?
				64'(rd_q[VALUE_WIDTH-1:0]) : '0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			table_size_q <= TABLE_SIZE_RESET;
			acc_q        <= HASH_SEED;
			rem_q        <= '0;
			cnt_q        <= '0;
			clr_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RESP);
			if (table_size_we) begin
				table_size_q <= table_size;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (request.key_last) begin
							acc_q   <= HASH_SEED;
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							acc_q <= hash_next;
						end
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? SLOT_OUT_W'(trial - divisor_q) : trial[SLOT_OUT_W-1:0];
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(HASH_W - 1)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

endmodule

@@ tb/tb_direct_mapped_hash_table.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the djb2 direct-mapped hash table: random key words against a scoreboard.
module tb_direct_mapped_hash_table;
	import dmht_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int SLOT_IDX_W = $clog2(TABLE_DEPTH);
	// Worst case is every word a last byte, each waiting out the whole division,
	// plus idle gaps; this is several times that for the whole run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	// The one command code the block does not act on.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              request = '0;
	logic              done;
	rsp_t              response;
	logic              table_size_we = 1'b0;
	logic [SIZE_W-1:0] table_size = TABLE_SIZE_RESET;

	direct_mapped_hash_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.done         (done),
		.response     (response),
		.table_size_we(table_size_we),
		.table_size   (table_size)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Key words waiting to be sent; the head is what sits on the request port.
	req_t word_q[$];
	// Responses the lookup shadow says are still to come, oldest first.
	rsp_t rsp_expected_q[$];

	// Shadow of the block's state, advanced as words are taken.
	logic [HASH_W-1:0] hash_acc;
	logic [SIZE_W-1:0] size_reg;
	logic              slot_live [TABLE_DEPTH];
	logic [63:0]       slot_word [TABLE_DEPTH];

	int  err_count = 0;
	int  cycle_count = 0;
	bit  steady = 1'b0;   // set for one phase: sender never idles

	// Divisor actually in use: zero acts as one, anything past the table saturates.
	function automatic logic [HASH_W-1:0] eff_size();
		if (size_reg == '0)
			return 64'd1;
		if (size_reg > TABLE_DEPTH)
			return 64'(TABLE_DEPTH);
		return 64'(size_reg);
	endfunction

	// Fold one taken word into the shadow hash; on the last byte, apply the
	// command to the shadow table and queue the response it must produce.
	task automatic apply_key_word(input req_t w);
		rsp_t r;
		logic [HASH_W-1:0] idx;
		int i;
		if (w.key_byte != 8'd0)
			hash_acc = hash_acc * 64'd33 + {56'd0, w.key_byte};
		if (w.key_last) begin
			idx = hash_acc % eff_size();
			hash_acc = HASH_SEED;
			i = int'(idx[SLOT_IDX_W-1:0]);
			r.found = slot_live[i];
			r.slot = idx[SLOT_OUT_W-1:0];
			r.value_out = '0;
			case (w.command)
				CMD_INSERT: begin
					slot_word[i] = w.value;
					slot_live[i] = 1'b1;
				end
				CMD_REMOVE: begin
					slot_live[i] = 1'b0;
				end
				CMD_RETRIEVE: begin
					// never-written slots are never valid, so never read here
					if (r.found)
						r.value_out = slot_word[i];
				end
				default: begin
				end
			endcase
			rsp_expected_q.push_back(r);
		end
	endtask

	// Driver: holds the head word on the port until taken, then either
	// presents the next one or idles instead (about 11 in 100).
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_key_word(request);
				void'(word_q.pop_front());
			end
			if (!start || !busy) begin
				if (word_q.size() > 0 && (steady || $urandom_range(99) >= 11)) begin
					start <= 1'b1;
					request <= word_q[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	// Monitor: done is a one-cycle strobe, so every high sample is a response.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (rsp_expected_q.size() == 0) begin
				flag_error($sformatf("unexpected response found=%0d slot=%0d value=%h",
					response.found, response.slot, response.value_out));
			end else begin
				want = rsp_expected_q.pop_front();
				if (response.found !== want.found || response.slot !== want.slot ||
						response.value_out !== want.value_out)
					flag_error($sformatf(
						"want found=%0d slot=%0d value=%h, got found=%0d slot=%0d value=%h",
						want.found, want.slot, want.value_out,
						response.found, response.slot, response.value_out));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL direct_mapped_hash_table");
			$finish;
		end
	end

	function automatic logic [63:0] rand_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic push_word(input logic [1:0] cmd, input logic [7:0] b, input logic last,
			input logic [63:0] val);
		req_t w;
		w.command = cmd;
		w.key_byte = b;
		w.key_last = last;
		w.value = val;
		word_q.push_back(w);
	endtask

	// One well-formed key: mostly short, some long enough to wrap the hash,
	// zero bytes mixed in, junk command/value on bytes before the last.
	task automatic queue_random_key(output int n);
		int pick;
		logic [1:0] cmd;
		pick = $urandom_range(99);
		if (pick < 75)
			n = $urandom_range(3, 1);
		else if (pick < 95)
			n = $urandom_range(8, 4);
		else
			n = $urandom_range(16, 12);
		pick = $urandom_range(99);
		if (pick < 40)
			cmd = CMD_INSERT;
		else if (pick < 75)
			cmd = CMD_RETRIEVE;
		else if (pick < 95)
			cmd = CMD_REMOVE;
		else
			cmd = CMD_UNUSED;
		for (int k = 0; k < n; k++)
			push_word((k == n - 1) ? cmd : 2'($urandom),
				($urandom_range(9) == 0) ? 8'd0 : 8'($urandom),
				k == n - 1, rand_value());
	endtask

	task automatic queue_random_words(input int target);
		int total, n;
		total = 0;
		while (total < target) begin
			queue_random_key(n);
			total += n;
		end
	endtask

	// Holds the caller until the word queue has drained, every response is in
	// and busy is low; only then is anything reconfigured.
	task automatic wait_idle();
		@(negedge clk);
		while (word_q.size() != 0 || rsp_expected_q.size() != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_table_size(input logic [SIZE_W-1:0] v);
		@(posedge clk);
		table_size_we <= 1'b1;
		table_size <= v;
		size_reg = v;
		@(posedge clk);
		table_size_we <= 1'b0;
	endtask

	initial begin
		hash_acc = HASH_SEED;
		size_reg = TABLE_SIZE_RESET;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			slot_live[i] = 1'b0;
			slot_word[i] = '0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset keeps busy high while it writes every slot
		repeat (TABLE_DEPTH + 8) @(negedge clk);
		while (busy)
			@(negedge clk);

		// Directed, reset table size. "A" and "Q" differ by 16 and collide.
		@(negedge clk);
		push_word(CMD_RETRIEVE, 8'h41, 1'b1, '1);          // empty table
		push_word(CMD_INSERT, 8'h41, 1'b1, '1);
		push_word(CMD_RETRIEVE, 8'h51, 1'b1, '0);          // collision hit
		push_word(CMD_INSERT, 8'h41, 1'b1, '0);            // overwrite
		push_word(CMD_RETRIEVE, 8'h41, 1'b1, '1);
		push_word(CMD_UNUSED, 8'h41, 1'b1, '1);            // reported, no effect
		push_word(CMD_REMOVE, 8'h41, 1'b1, '1);
		push_word(CMD_REMOVE, 8'h51, 1'b1, '1);            // already gone
		push_word(CMD_RETRIEVE, 8'h41, 1'b1, '1);
		push_word(CMD_INSERT, 8'h00, 1'b1, 64'h5555_5555_5555_5555); // zero key byte
		push_word(CMD_UNUSED, 8'h00, 1'b0, '1);
		push_word(CMD_RETRIEVE, 8'hFF, 1'b1, '0);
		// long key: accumulator wraps past 64 bits
		for (int k = 0; k < 11; k++)
			push_word(2'(k), 8'hFF, 1'b0, rand_value());
		push_word(CMD_INSERT, 8'h80, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
		wait_idle();

		// Random phases over the interesting table sizes.
		set_table_size(17'd1);
		@(negedge clk);
		queue_random_words(100);
		wait_idle();

		set_table_size(17'd0);      // acts as one slot
		@(negedge clk);
		queue_random_words(60);
		wait_idle();

		set_table_size(17'h10000);  // saturates
		@(negedge clk);
		queue_random_words(100);
		wait_idle();

		steady = 1'b1;
		set_table_size(17'h1FFFF);
		@(negedge clk);
		queue_random_words(100);
		wait_idle();
		steady = 1'b0;

		set_table_size(17'd5);
		@(negedge clk);
		queue_random_words(120);
		wait_idle();

		set_table_size(17'd16);
		@(negedge clk);
		queue_random_words(120);
		wait_idle();

		set_table_size(SIZE_W'($urandom_range(15, 2)));
		@(negedge clk);
		queue_random_words(100);
		wait_idle();

		// tail: nothing more may show up after the last response
		repeat (80) @(negedge clk);
		if (err_count == 0 && rsp_expected_q.size() == 0) begin
			$display("PASS direct_mapped_hash_table");
		end else begin
			$display("FAIL direct_mapped_hash_table");
		end
		$finish;
	end

endmodule
